/* rtl/sods_pkg.sv */
// shared types, constants and helper functions of the sumo opponent drive sequencer
`default_nettype none

package sods_pkg;

    // sensor readings are taken in their low SENSOR_BITS bits
    localparam int SENSOR_BITS = 12;
    localparam int FIELD_W     = 12;
    localparam logic [FIELD_W-1:0] SENSOR_MASK =
        (SENSOR_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                                 : FIELD_W'((1 << SENSOR_BITS) - 1);

    localparam int RANGE_LANES = 5;
    localparam int LANE_IDX_W  = $clog2(RANGE_LANES);

    // input transaction layout
    localparam int OPCODE_W    = 3;
    localparam int TIME_W      = 32;
    localparam int S_TDATA_W   = 176;
    localparam int LINE_BASE   = 2 * TIME_W;
    localparam int RANGE_BASE  = LINE_BASE + 4 * FIELD_W;

    // result transaction layout
    localparam int DRIVE_W     = 11;
    localparam int M_TDATA_W   = 24;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BEHAVIOR_KIND  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_PERIOD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_ARM       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FLANK_BURST    = 3'd5;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ARM    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_ARM_DL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_STOP   = 3'd3;

    // behaviour kinds
    localparam logic [1:0] KIND_STATIC  = 2'd0;
    localparam logic [1:0] KIND_CHARGER = 2'd1;
    localparam logic [1:0] KIND_SPINNER = 2'd2;
    localparam logic [1:0] KIND_FLANK   = 2'd3;

    // drive levels in per-mille
    localparam logic signed [11:0] DRV_ZERO       = 12'sd0;
    localparam logic signed [11:0] DRV_FULL       = 12'sd1000;
    localparam logic signed [11:0] DRV_FLANK_R    = 12'sd400;
    localparam logic signed [11:0] DRV_SPIN_EDGE  = -12'sd600;
    localparam logic signed [11:0] DRV_SPIN       = 12'sd500;
    localparam logic signed [11:0] DRV_BACK       = -12'sd850;
    localparam logic signed [11:0] DRV_TURN       = 12'sd600;
    localparam logic signed [11:0] DRV_PUSH       = 12'sd900;
    localparam logic signed [11:0] DRV_CHARGE     = 12'sd950;
    localparam logic signed [11:0] DRV_SEARCH     = 12'sd450;

    // back-off timing in milliseconds
    localparam logic [15:0] BACK_TURN_MS = 16'd300;
    localparam logic [15:0] BACK_END_MS  = 16'd700;

    // per-lane range result
    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] level;
    } lane_res_t;

    // merged nearest contact
    typedef struct packed {
        logic                  found;
        logic [LANE_IDX_W-1:0] idx;
    } nearest_t;

    function automatic logic [FIELD_W-1:0] sensor_f(input logic [FIELD_W-1:0] raw);
        return raw & SENSOR_MASK;
    endfunction

    // steering offset per range lane, left sixty first
    function automatic logic signed [11:0] turn_f(input logic [LANE_IDX_W-1:0] idx);
        logic signed [11:0] t;
        case (idx)
            3'd0:    t = 12'sd550;
            3'd1:    t = 12'sd275;
            3'd3:    t = -12'sd275;
            3'd4:    t = -12'sd550;
            default: t = 12'sd0;
        endcase
        return t;
    endfunction

    function automatic logic [DRIVE_W-1:0] clamp_f(input logic signed [11:0] v);
        logic signed [11:0] c;
        if (v > DRV_FULL) begin
            c = DRV_FULL;
        end else if (v < -DRV_FULL) begin
            c = -DRV_FULL;
        end else begin
            c = v;
        end
        return c[DRIVE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/sumo_opponent_drive_sequencer.sv */
// top level of the sumo opponent drive sequencer: arming, drive choice and output skid
//
//  channel | direction | handshake             | payload
//  s_      | in        | s_tvalid / s_tready   | s_tdata fields, s_tuser opcode
//  m_      | out       | m_tvalid / m_tready   | m_tdata drive pair and armed flag
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one transaction a cycle while s_tready is high; a tick's result is registered into the
// output register, or into the skid entry when the output stalls; a message gives none.
// the whole decision is combinational logic after the five range lanes and their merge.
// reset clears state and configuration to defaults. a two-entry output stage (register
// plus skid) lets input flow on while a result waits; s_tready drops only when both entries are full.
`default_nettype none

module sumo_opponent_drive_sequencer
    import sods_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // config write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // fields from bit 0: time_ms, given_deadline_ms, line_front_left,
    // line_front_right, line_rear_left, line_rear_right, range_left_60,
    // range_left_30, range_center, range_right_30, range_right_60, zero pad
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // fields from bit 0: opcode
    input  wire logic [OPCODE_W-1:0]    s_tuser,
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // fields from bit 0: left_drive, right_drive, is_armed, zero pad
    output logic [M_TDATA_W-1:0]        m_tdata
);

    // configuration registers
    logic [1:0]         kind_reg;
    logic [9:0]         period_reg;
    logic [FIELD_W-1:0] line_th_reg;
    logic [FIELD_W-1:0] range_lim_reg;
    logic [15:0]        auto_arm_reg;
    logic [15:0]        flank_reg;

    // controller state
    logic               armed_reg, armed_next;
    logic               heard_reg, heard_next;
    logic               dl_set_reg, dl_set_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic [TIME_W:0]    since_reg, since_next;
    logic               backing_reg, backing_next;
    logic [15:0]        elapsed_reg, elapsed_next;

    // output stage
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg, skid_data_next;

    logic                 in_acc;
    logic                 push;
    logic                 main_free;
    logic [M_TDATA_W-1:0] result;

    // input fields
    logic [OPCODE_W-1:0] opcode;
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   given_dl;
    logic [FIELD_W-1:0]  line_fl, line_fr, line_rl, line_rr;
    logic [FIELD_W-1:0]  range_rd [RANGE_LANES];

    // derived tick values
    logic                lf, lr;
    logic                dl_hit;
    logic                armed_t;
    logic [TIME_W:0]     since_t;
    logic signed [33:0]  since_diff;
    logic                flank_on;
    logic [TIME_W:0]     dl_sum;
    logic [15:0]         elapsed_base;
    logic [16:0]         elapsed_sum;
    logic [15:0]         elapsed_sat;
    logic signed [11:0]  turn;
    logic signed [11:0]  drv_l, drv_r;

    lane_res_t [RANGE_LANES-1:0] lane_res;
    nearest_t                    near;

    assign opcode   = s_tuser;
    assign now      = s_tdata[TIME_W-1:0];
    assign given_dl = s_tdata[2*TIME_W-1:TIME_W];
    assign line_fl  = s_tdata[LINE_BASE             +: FIELD_W];
    assign line_fr  = s_tdata[LINE_BASE + FIELD_W   +: FIELD_W];
    assign line_rl  = s_tdata[LINE_BASE + 2*FIELD_W +: FIELD_W];
    assign line_rr  = s_tdata[LINE_BASE + 3*FIELD_W +: FIELD_W];

    // range lanes and merge
    for (genvar i = 0; i < RANGE_LANES; i++) begin : g_lane
        assign range_rd[i] = s_tdata[RANGE_BASE + i*FIELD_W +: FIELD_W];
        sods_range_lane u_lane (
            .reading     (range_rd[i]),
            .range_limit (range_lim_reg),
            .result      (lane_res[i])
        );
    end

    sods_nearest_merge u_merge (
        .lanes   (lane_res),
        .nearest (near)
    );

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign push      = in_acc && (opcode == OP_TICK);
    assign main_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= KIND_CHARGER;
            period_reg    <= 10'd32;
            line_th_reg   <= 12'd400;
            range_lim_reg <= 12'd1190;
            auto_arm_reg  <= 16'd5000;
            flank_reg     <= 16'd350;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BEHAVIOR_KIND:  kind_reg      <= cfg_data[1:0];
                REG_TICK_PERIOD:    period_reg    <= cfg_data[9:0];
                REG_LINE_THRESHOLD: line_th_reg   <= cfg_data[FIELD_W-1:0];
                REG_RANGE_LIMIT:    range_lim_reg <= cfg_data[FIELD_W-1:0];
                REG_AUTO_ARM:       auto_arm_reg  <= cfg_data;
                REG_FLANK_BURST:    flank_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // edges, arming and timers for the current tick
    assign lf = (sensor_f(line_fl) > line_th_reg) || (sensor_f(line_fr) > line_th_reg);
    assign lr = (sensor_f(line_rl) > line_th_reg) || (sensor_f(line_rr) > line_th_reg);

    assign dl_hit  = !armed_reg && dl_set_reg && (now >= deadline_reg);
    assign since_t = dl_hit ? {1'b0, now} : since_reg;
    assign armed_t = armed_reg || dl_hit
                     || (!heard_reg && (now >= {16'd0, auto_arm_reg}));

    assign since_diff = $signed({2'b00, now}) - $signed({since_t[TIME_W], since_t});
    assign flank_on   = since_diff < $signed({18'd0, flank_reg});

    assign dl_sum = {1'b0, now} + {17'd0, auto_arm_reg};

    assign elapsed_base = (lf && !backing_reg) ? 16'd0 : elapsed_reg;
    assign elapsed_sum  = {1'b0, elapsed_base} + {7'd0, period_reg};
    assign elapsed_sat  = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];

    assign turn = turn_f(near.idx);

    // next state and drive choice
    always_comb begin
        armed_next    = armed_reg;
        heard_next    = heard_reg;
        dl_set_next   = dl_set_reg;
        deadline_next = deadline_reg;
        since_next    = since_reg;
        backing_next  = backing_reg;
        elapsed_next  = elapsed_reg;
        drv_l         = DRV_ZERO;
        drv_r         = DRV_ZERO;

        if (opcode != OP_TICK) begin
            heard_next = 1'b1;
            if ((opcode == OP_ARM || opcode == OP_ARM_DL) && !armed_reg && !dl_set_reg) begin
                if (opcode == OP_ARM) begin
                    deadline_next = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
                end else begin
                    deadline_next = given_dl;
                end
                dl_set_next  = 1'b1;
                backing_next = 1'b0;
            end else if (opcode == OP_STOP) begin
                armed_next  = 1'b0;
                dl_set_next = 1'b0;
            end
        end else begin
            armed_next = armed_t;
            since_next = since_t;
            if (armed_t && kind_reg != KIND_STATIC) begin
                if (kind_reg == KIND_FLANK && flank_on && !lf && !lr) begin
                    drv_l = DRV_FULL;
                    drv_r = DRV_FLANK_R;
                end else if (kind_reg == KIND_SPINNER) begin
                    if (lf || lr) begin
                        drv_l = DRV_SPIN_EDGE;
                        drv_r = DRV_SPIN_EDGE;
                    end else begin
                        drv_l = -DRV_SPIN;
                        drv_r = DRV_SPIN;
                    end
                end else if (backing_reg || lf) begin
                    // timed back-off: reverse, then turn on the spot
                    elapsed_next = elapsed_sat;
                    if (elapsed_sat < BACK_TURN_MS) begin
                        drv_l = DRV_BACK;
                        drv_r = DRV_BACK;
                    end else begin
                        drv_l = -DRV_TURN;
                        drv_r = DRV_TURN;
                    end
                    backing_next = !(elapsed_sat > BACK_END_MS);
                end else if (lr) begin
                    drv_l = DRV_PUSH;
                    drv_r = DRV_PUSH;
                end else if (near.found) begin
                    drv_l = DRV_CHARGE - turn;
                    drv_r = DRV_CHARGE + turn;
                end else begin
                    drv_l = -DRV_SEARCH;
                    drv_r = DRV_SEARCH;
                end
            end
        end
    end

    assign result = {1'b0, armed_t, clamp_f(drv_r), clamp_f(drv_l)};

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg    <= 1'b0;
            heard_reg    <= 1'b0;
            dl_set_reg   <= 1'b0;
            deadline_reg <= '0;
            since_reg    <= '1;
            backing_reg  <= 1'b0;
            elapsed_reg  <= '0;
        end else if (in_acc) begin
            armed_reg    <= armed_next;
            heard_reg    <= heard_next;
            dl_set_reg   <= dl_set_next;
            deadline_reg <= deadline_next;
            since_reg    <= since_next;
            backing_reg  <= backing_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // output register and skid entry
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = result;
            end else begin
                m_valid_next = push;
                m_data_next  = result;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    // a waiting skid entry always sits behind a valid output
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without a valid output");

    // a disarmed result never drives the wheels
    a_disarmed_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[2*DRIVE_W]) |-> (m_data_reg[2*DRIVE_W-1:0] == '0))
        else $error("wheel drive while disarmed");

    // drive commands stay within full scale
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(m_data_reg[DRIVE_W-1:0]) >= -11'sd1000
                         && $signed(m_data_reg[DRIVE_W-1:0]) <= 11'sd1000
                         && $signed(m_data_reg[2*DRIVE_W-1:DRIVE_W]) >= -11'sd1000
                         && $signed(m_data_reg[2*DRIVE_W-1:DRIVE_W]) <= 11'sd1000))
        else $error("drive command beyond full scale");

    // an accepted arm message on a disarmed controller sets the deadline
    a_arm_sets_deadline: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (opcode == OP_ARM || opcode == OP_ARM_DL) && !armed_reg && !dl_set_reg)
        |=> (dl_set_reg && !backing_reg))
        else $error("arm message did not set the deadline");

    // a stalled output keeps its result
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("output result changed under stall");

endmodule

`default_nettype wire

/* rtl/sods_range_lane.sv */
// one range lane: masks a reading and flags a contact below the range limit
`default_nettype none

module sods_range_lane
    import sods_pkg::*;
(
    input  wire logic [FIELD_W-1:0] reading,
    input  wire logic [FIELD_W-1:0] range_limit,
    output lane_res_t               result
);

    logic [FIELD_W-1:0] value;

    // contact when the masked reading is under the limit
    assign value        = sensor_f(reading);
    assign result.level = value;
    assign result.hit   = (value < range_limit);

endmodule

`default_nettype wire

/* rtl/sods_nearest_merge.sv */
// merge of the range lanes: nearest contact, first lane wins on ties
`default_nettype none

module sods_nearest_merge
    import sods_pkg::*;
(
    input  wire lane_res_t [RANGE_LANES-1:0] lanes,
    output nearest_t                         nearest
);

    // strict compare keeps the lowest index on equal distances
    always_comb begin
        logic [FIELD_W-1:0] best;
        nearest.found = 1'b0;
        nearest.idx   = '0;
        best          = '0;
        for (int i = 0; i < RANGE_LANES; i++) begin
            if (lanes[i].hit && (!nearest.found || lanes[i].level < best)) begin
                nearest.found = 1'b1;
                nearest.idx   = LANE_IDX_W'(i);
                best          = lanes[i].level;
            end
        end
    end

endmodule

`default_nettype wire
